FILE: hw/rtl/ccc_pkg.sv
// shared constants for the circle pair contact pipeline
package ccc_pkg;

   localparam int unsigned COORD_WIDTH_DEF = 24;
   localparam int unsigned RADIUS_WIDTH    = 16;
   localparam int unsigned RSUM_WIDTH      = RADIUS_WIDTH + 1;
   localparam int unsigned SQ_WIDTH        = 2 * RSUM_WIDTH;
   localparam int unsigned FRAC_BITS       = 8;
   localparam int unsigned RAD_FRAC        = 2 * FRAC_BITS;
   localparam int unsigned DIST_WIDTH      = RSUM_WIDTH + FRAC_BITS;
   localparam int unsigned RAD_WIDTH       = 2 * DIST_WIDTH;
   localparam int unsigned NORM_WIDTH      = 16;
   localparam int unsigned NMAG_WIDTH      = 15;
   localparam int unsigned NORM_ONE        = 16384;
   localparam int unsigned DIV_SHIFT       = 23;
   localparam int unsigned DIVD_WIDTH      = RSUM_WIDTH + DIV_SHIFT + 1;
   localparam int unsigned DEPTH_WIDTH     = 17;
   localparam int unsigned DEPTH_SUM_WIDTH = DIST_WIDTH + 1;
   localparam int unsigned DEPTH_ROUND     = 128;
   localparam int unsigned PROD_WIDTH      = NMAG_WIDTH + RADIUS_WIDTH;
   localparam int unsigned NORM_FRAC       = 14;
   localparam int unsigned PROD_ROUND      = 8192;
   localparam int unsigned OFS_WIDTH       = PROD_WIDTH + 1 - NORM_FRAC;

endpackage

FILE: hw/rtl/ccc_req_if.sv
// request channel: one circle pair per item
interface ccc_req_if #(
   parameter int unsigned COORD_WIDTH = ccc_pkg::COORD_WIDTH_DEF
);
   logic                                  valid;
   logic                                  ready;
   logic signed [COORD_WIDTH-1:0]         center_a_x;
   logic signed [COORD_WIDTH-1:0]         center_a_y;
   logic [ccc_pkg::RADIUS_WIDTH-1:0]      radius_a;
   logic signed [COORD_WIDTH-1:0]         center_b_x;
   logic signed [COORD_WIDTH-1:0]         center_b_y;
   logic [ccc_pkg::RADIUS_WIDTH-1:0]      radius_b;

   modport source (
      output valid, center_a_x, center_a_y, radius_a, center_b_x, center_b_y, radius_b,
      input  ready
   );
   modport sink (
      input  valid, center_a_x, center_a_y, radius_a, center_b_x, center_b_y, radius_b,
      output ready
   );
endinterface

FILE: hw/rtl/ccc_rsp_if.sv
// response channel: one contact result per item
interface ccc_rsp_if #(
   parameter int unsigned COORD_WIDTH = ccc_pkg::COORD_WIDTH_DEF
);
   logic                                  valid;
   logic                                  ready;
   logic                                  collides;
   logic signed [ccc_pkg::NORM_WIDTH-1:0] normal_x;
   logic signed [ccc_pkg::NORM_WIDTH-1:0] normal_y;
   logic signed [COORD_WIDTH-1:0]         start_x;
   logic signed [COORD_WIDTH-1:0]         start_y;
   logic signed [COORD_WIDTH-1:0]         end_x;
   logic signed [COORD_WIDTH-1:0]         end_y;
   logic [ccc_pkg::DEPTH_WIDTH-1:0]       depth;

   modport source (
      output valid, collides, normal_x, normal_y, start_x, start_y, end_x, end_y, depth,
      input  ready
   );
   modport sink (
      input  valid, collides, normal_x, normal_y, start_x, start_y, end_x, end_y, depth,
      output ready
   );
endinterface

FILE: hw/rtl/circle_circle_contact.sv
// circle pair contact test: top level pipeline
//
// req carries one circle pair per item (centres signed, radii unsigned, both with
// 8 fraction bits); rsp returns one contact result per item, in order.
// collides is 1 when the circles touch or overlap; then rsp gives the unit
// normal from A to B in Q1.14, the contact points on A (end) and on B (start),
// saturated to the coordinate range, and the penetration depth. On a miss all
// other fields are zero.
// from req acceptance to rsp valid an item passes the distance test stages, 25 square
// root stages (one root bit per stage), 16 divide stages (one prep, one quotient
// bit each), then multiply, round and add/saturate stages.
// throughput is one item per cycle while rsp is not stalled; the pipeline holds up to 47 items.
// every stage moves only while the output register is empty or being taken,
// so a stall on rsp holds all items in place and req.ready drops with it.
// synchronous reset clears all valid bits; payload registers are not reset.
module circle_circle_contact #(
   parameter int unsigned COORD_WIDTH = ccc_pkg::COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   ccc_req_if.sink   req,
   ccc_rsp_if.source rsp
);
   localparam int unsigned RSW   = ccc_pkg::RSUM_WIDTH;
   localparam int unsigned RDW   = ccc_pkg::RADIUS_WIDTH;
   localparam int unsigned SQW   = ccc_pkg::SQ_WIDTH;
   localparam int unsigned DTW   = ccc_pkg::DIST_WIDTH;
   localparam int unsigned NMW   = ccc_pkg::NMAG_WIDTH;
   localparam int unsigned NRW   = ccc_pkg::NORM_WIDTH;
   localparam int unsigned PW    = ccc_pkg::PROD_WIDTH;
   localparam int unsigned OW    = ccc_pkg::OFS_WIDTH;
   localparam int unsigned DW    = COORD_WIDTH + 1;
   localparam int unsigned CMP_W = (DW > RSW) ? DW : RSW;
   localparam int unsigned SW    = ((COORD_WIDTH > OW) ? COORD_WIDTH : OW) + 2;
   localparam int unsigned DSW   = ccc_pkg::DEPTH_SUM_WIDTH;
   localparam int unsigned DPW   = ccc_pkg::DEPTH_WIDTH;
   localparam int unsigned FB    = ccc_pkg::FRAC_BITS;
   localparam logic signed [SW-1:0] SAT_HI = SW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
   localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

   typedef struct packed {
      logic                          hit;
      logic                          sx;
      logic                          sy;
      logic [RSW-1:0]                rsum;
      logic [RDW-1:0]                ra;
      logic [RDW-1:0]                rb;
      logic signed [COORD_WIDTH-1:0] ax;
      logic signed [COORD_WIDTH-1:0] ay;
      logic signed [COORD_WIDTH-1:0] bx;
      logic signed [COORD_WIDTH-1:0] by;
   } ctx_type;

   typedef struct packed {
      ctx_type        ctx;
      logic [RSW-1:0] adx;
      logic [RSW-1:0] ady;
   } sq_side_type;

   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   // stage 1: centre differences, radius sum, per-axis reject
   logic signed [DW-1:0] dx_in, dy_in;
   logic [CMP_W-1:0]     adx_in, ady_in;
   logic [RSW-1:0]       rsum_in;
   logic                 near_in;
   ctx_type              ctx_in;

   assign rsum_in = RSW'(req.radius_a) + RSW'(req.radius_b);
   assign dx_in   = DW'(req.center_b_x) - DW'(req.center_a_x);
   assign dy_in   = DW'(req.center_b_y) - DW'(req.center_a_y);
   assign adx_in  = CMP_W'($unsigned(dx_in[DW-1] ? -dx_in : dx_in));
   assign ady_in  = CMP_W'($unsigned(dy_in[DW-1] ? -dy_in : dy_in));
   assign near_in = (adx_in <= CMP_W'(rsum_in)) && (ady_in <= CMP_W'(rsum_in));

   always_comb begin
      ctx_in.hit  = 1'b0;
      ctx_in.sx   = dx_in[DW-1];
      ctx_in.sy   = dy_in[DW-1];
      ctx_in.rsum = rsum_in;
      ctx_in.ra   = req.radius_a;
      ctx_in.rb   = req.radius_b;
      ctx_in.ax   = req.center_a_x;
      ctx_in.ay   = req.center_a_y;
      ctx_in.bx   = req.center_b_x;
      ctx_in.by   = req.center_b_y;
   end

   logic           v1_ff, near1_ff;
   ctx_type        ctx1_ff;
   logic [RSW-1:0] adx1_ff, ady1_ff;

   // stage 2: squares
   logic           v2_ff, near2_ff;
   ctx_type        ctx2_ff;
   logic [RSW-1:0] adx2_ff, ady2_ff;
   logic [SQW-1:0] sqx2_ff, sqy2_ff, rsq2_ff;

   // stage 3: squared distance against squared radius sum
   logic [SQW:0]                     d2_in;
   logic                             hit_in;
   sq_side_type                      side3_in;
   logic                             v3_ff;
   sq_side_type                      side3_ff;
   logic [ccc_pkg::RAD_WIDTH-1:0]    radicand3_ff;

   assign d2_in  = (SQW + 1)'(sqx2_ff) + (SQW + 1)'(sqy2_ff);
   assign hit_in = near2_ff && (d2_in <= (SQW + 1)'(rsq2_ff));

   always_comb begin
      side3_in.ctx     = ctx2_ff;
      side3_in.ctx.hit = hit_in;
      side3_in.adx     = adx2_ff;
      side3_in.ady     = ady2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (en) begin
         near1_ff <= near_in;
         ctx1_ff  <= ctx_in;
         adx1_ff  <= adx_in[RSW-1:0];
         ady1_ff  <= ady_in[RSW-1:0];

         near2_ff <= near1_ff;
         ctx2_ff  <= ctx1_ff;
         adx2_ff  <= adx1_ff;
         ady2_ff  <= ady1_ff;
         sqx2_ff  <= SQW'(adx1_ff) * SQW'(adx1_ff);
         sqy2_ff  <= SQW'(ady1_ff) * SQW'(ady1_ff);
         rsq2_ff  <= SQW'(ctx1_ff.rsum) * SQW'(ctx1_ff.rsum);

         side3_ff     <= side3_in;
         radicand3_ff <= hit_in ? {d2_in[SQW-1:0], {ccc_pkg::RAD_FRAC{1'b0}}} : '0;
      end
   end

   // distance with 16 fraction bits
   logic           sq_valid;
   logic [DTW-1:0] sq_root;
   sq_side_type    sq_side;

   ccc_isqrt #(
      .SIDE_WIDTH ($bits(sq_side_type))
   ) u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (v3_ff),
      .in_radicand (radicand3_ff),
      .in_side     (side3_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   // normal magnitudes
   logic           dv_valid;
   logic [NMW-1:0] dv_nmag_x, dv_nmag_y;
   logic [DTW-1:0] dv_dist;
   ctx_type        dv_ctx;

   ccc_ndiv #(
      .SIDE_WIDTH ($bits(ctx_type))
   ) u_ndiv (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (sq_valid),
      .in_mag_x   (sq_side.adx),
      .in_mag_y   (sq_side.ady),
      .in_dist    (sq_root),
      .in_side    (sq_side.ctx),
      .out_valid  (dv_valid),
      .out_nmag_x (dv_nmag_x),
      .out_nmag_y (dv_nmag_y),
      .out_dist   (dv_dist),
      .out_side   (dv_ctx)
   );

   // stage 4: normal times radius
   logic           v4_ff;
   ctx_type        ctx4_ff;
   logic [NMW-1:0] nmx4_ff, nmy4_ff;
   logic [DTW-1:0] dist4_ff;
   logic [PW-1:0]  pxa4_ff, pya4_ff, pxb4_ff, pyb4_ff;

   // stage 5: rounding, signed normal, depth
   function automatic logic [OW-1:0] round_ofs(input logic [PW-1:0] p);
      logic [PW:0] rnd;
      rnd = (PW + 1)'(p) + (PW + 1)'(ccc_pkg::PROD_ROUND);
      return rnd[PW:ccc_pkg::NORM_FRAC];
   endfunction

   function automatic logic signed [NRW-1:0] sign_norm(input logic [NMW-1:0] m,
                                                       input logic neg);
      logic signed [NRW-1:0] v;
      v = $signed(NRW'(m));
      return neg ? -v : v;
   endfunction

   logic [DSW-1:0] dsum_in;
   assign dsum_in = (DSW'(ctx4_ff.rsum) << FB) - DSW'(dist4_ff) + DSW'(ccc_pkg::DEPTH_ROUND);

   logic                  v5_ff;
   ctx_type               ctx5_ff;
   logic signed [NRW-1:0] nx5_ff, ny5_ff;
   logic [OW-1:0]         oxa5_ff, oya5_ff, oxb5_ff, oyb5_ff;
   logic [DPW-1:0]        depth5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= dv_valid;
         v5_ff <= v4_ff;
      end
      if (en) begin
         ctx4_ff  <= dv_ctx;
         nmx4_ff  <= dv_nmag_x;
         nmy4_ff  <= dv_nmag_y;
         dist4_ff <= dv_dist;
         pxa4_ff  <= PW'(dv_nmag_x) * PW'(dv_ctx.ra);
         pya4_ff  <= PW'(dv_nmag_y) * PW'(dv_ctx.ra);
         pxb4_ff  <= PW'(dv_nmag_x) * PW'(dv_ctx.rb);
         pyb4_ff  <= PW'(dv_nmag_y) * PW'(dv_ctx.rb);

         ctx5_ff   <= ctx4_ff;
         nx5_ff    <= sign_norm(nmx4_ff, ctx4_ff.sx);
         ny5_ff    <= sign_norm(nmy4_ff, ctx4_ff.sy);
         oxa5_ff   <= round_ofs(pxa4_ff);
         oya5_ff   <= round_ofs(pya4_ff);
         oxb5_ff   <= round_ofs(pxb4_ff);
         oyb5_ff   <= round_ofs(pyb4_ff);
         depth5_ff <= dsum_in[DPW+FB-1:FB];
      end
   end

   // stage 6: contact points, saturation, output register
   function automatic logic signed [COORD_WIDTH-1:0] move_sat(
      input logic signed [COORD_WIDTH-1:0] c,
      input logic                          neg,
      input logic [OW-1:0]                 m
   );
      logic signed [SW-1:0] o;
      logic signed [SW-1:0] s;
      o = $signed(SW'(m));
      s = neg ? (SW'(c) - o) : (SW'(c) + o);
      if (s > SAT_HI) begin
         return SAT_HI[COORD_WIDTH-1:0];
      end
      if (s < SAT_LO) begin
         return SAT_LO[COORD_WIDTH-1:0];
      end
      return s[COORD_WIDTH-1:0];
   endfunction

   logic                          collides_ff;
   logic signed [NRW-1:0]         normal_x_ff, normal_y_ff;
   logic signed [COORD_WIDTH-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic [DPW-1:0]                depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v5_ff;
      end
      if (en) begin
         collides_ff <= ctx5_ff.hit;
         if (ctx5_ff.hit) begin
            normal_x_ff <= nx5_ff;
            normal_y_ff <= ny5_ff;
            end_x_ff    <= move_sat(ctx5_ff.ax, ctx5_ff.sx, oxa5_ff);
            end_y_ff    <= move_sat(ctx5_ff.ay, ctx5_ff.sy, oya5_ff);
            start_x_ff  <= move_sat(ctx5_ff.bx, !ctx5_ff.sx, oxb5_ff);
            start_y_ff  <= move_sat(ctx5_ff.by, !ctx5_ff.sy, oyb5_ff);
            depth_ff    <= depth5_ff;
         end else begin
            normal_x_ff <= '0;
            normal_y_ff <= '0;
            end_x_ff    <= '0;
            end_y_ff    <= '0;
            start_x_ff  <= '0;
            start_y_ff  <= '0;
            depth_ff    <= '0;
         end
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.collides = collides_ff;
   assign rsp.normal_x = normal_x_ff;
   assign rsp.normal_y = normal_y_ff;
   assign rsp.start_x  = start_x_ff;
   assign rsp.start_y  = start_y_ff;
   assign rsp.end_x    = end_x_ff;
   assign rsp.end_y    = end_y_ff;
   assign rsp.depth    = depth_ff;

   a_reset_idle: assert property (@(posedge clock) $past(reset) |-> !rsp.valid)
      else $error("rsp valid right after reset");

   a_stall_upstream: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("req taken while output held");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.collides |-> rsp.normal_x == '0 && rsp.normal_y == '0 &&
         rsp.depth == '0 && rsp.end_x == '0 && rsp.start_x == '0)
      else $error("miss item with nonzero fields");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.collides |-> rsp.normal_x <= 16384 && rsp.normal_x >= -16384 &&
         rsp.normal_y <= 16384 && rsp.normal_y >= -16384)
      else $error("normal out of unit range");

endmodule

FILE: hw/rtl/ccc_isqrt.sv
// pipelined integer square root, one result bit per stage
module ccc_isqrt #(
   parameter int unsigned SIDE_WIDTH = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [ccc_pkg::RAD_WIDTH-1:0]    in_radicand,
   input  logic [SIDE_WIDTH-1:0]            in_side,
   output logic                             out_valid,
   output logic [ccc_pkg::DIST_WIDTH-1:0]   out_root,
   output logic [SIDE_WIDTH-1:0]            out_side
);
   localparam int unsigned NSTG = ccc_pkg::DIST_WIDTH;
   localparam int unsigned RW   = ccc_pkg::RAD_WIDTH + 1;

   logic [RW-1:0]         rem_ff   [NSTG];
   logic [NSTG-1:0]       root_ff  [NSTG];
   logic [SIDE_WIDTH-1:0] side_ff  [NSTG];
   logic                  valid_ff [NSTG];

   for (genvar k = 0; k < NSTG; k++) begin : g_stage
      localparam int unsigned BIT = NSTG - 1 - k;
      logic [RW-1:0]         rem_src;
      logic [NSTG-1:0]       root_src;
      logic [SIDE_WIDTH-1:0] side_src;
      logic                  valid_src;
      logic [RW-1:0]         trial;
      logic [RW-1:0]         rem_in;
      logic [NSTG-1:0]       root_in;

      if (k == 0) begin : g_first
         assign rem_src   = RW'(in_radicand);
         assign root_src  = '0;
         assign side_src  = in_side;
         assign valid_src = in_valid;
      end else begin : g_next
         assign rem_src   = rem_ff[k-1];
         assign root_src  = root_ff[k-1];
         assign side_src  = side_ff[k-1];
         assign valid_src = valid_ff[k-1];
      end

      // try setting this bit: (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
      assign trial = (RW'(root_src) << (BIT + 1)) + (RW'(1) << (2 * BIT));

      always_comb begin
         if (rem_src >= trial) begin
            rem_in  = rem_src - trial;
            root_in = root_src | (NSTG'(1) << BIT);
         end else begin
            rem_in  = rem_src;
            root_in = root_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_src;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[NSTG-1];
   assign out_root  = root_ff[NSTG-1];
   assign out_side  = side_ff[NSTG-1];

endmodule

FILE: hw/rtl/ccc_ndiv.sv
// pipelined two-lane rounded divide for the unit normal
module ccc_ndiv #(
   parameter int unsigned SIDE_WIDTH = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [ccc_pkg::RSUM_WIDTH-1:0]   in_mag_x,
   input  logic [ccc_pkg::RSUM_WIDTH-1:0]   in_mag_y,
   input  logic [ccc_pkg::DIST_WIDTH-1:0]   in_dist,
   input  logic [SIDE_WIDTH-1:0]            in_side,
   output logic                             out_valid,
   output logic [ccc_pkg::NMAG_WIDTH-1:0]   out_nmag_x,
   output logic [ccc_pkg::NMAG_WIDTH-1:0]   out_nmag_y,
   output logic [ccc_pkg::DIST_WIDTH-1:0]   out_dist,
   output logic [SIDE_WIDTH-1:0]            out_side
);
   localparam int unsigned QW  = ccc_pkg::NMAG_WIDTH;
   localparam int unsigned NW  = ccc_pkg::DIVD_WIDTH;
   localparam int unsigned DTW = ccc_pkg::DIST_WIDTH;

   // prep stage: numerator = mag * 2^23 + dist, denominator = 2 * dist
   logic [NW-1:0]         num_p_ff [2];
   logic [DTW-1:0]        dist_p_ff;
   logic [SIDE_WIDTH-1:0] side_p_ff;
   logic                  valid_p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_p_ff <= 1'b0;
      end else if (en) begin
         valid_p_ff <= in_valid;
      end
      if (en) begin
         num_p_ff[0] <= (NW'(in_mag_x) << ccc_pkg::DIV_SHIFT) + NW'(in_dist);
         num_p_ff[1] <= (NW'(in_mag_y) << ccc_pkg::DIV_SHIFT) + NW'(in_dist);
         dist_p_ff   <= in_dist;
         side_p_ff   <= in_side;
      end
   end

   logic [NW-1:0]         rem_ff   [QW][2];
   logic [QW-1:0]         quo_ff   [QW][2];
   logic [DTW-1:0]        dist_ff  [QW];
   logic [SIDE_WIDTH-1:0] side_ff  [QW];
   logic                  valid_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int unsigned BIT = QW - 1 - k;
      logic [NW-1:0]         rem_src [2];
      logic [QW-1:0]         quo_src [2];
      logic [DTW-1:0]        dist_src;
      logic [SIDE_WIDTH-1:0] side_src;
      logic                  valid_src;
      logic [NW-1:0]         trial;
      logic [NW-1:0]         rem_in  [2];
      logic [QW-1:0]         quo_in  [2];

      if (k == 0) begin : g_first
         assign rem_src[0] = num_p_ff[0];
         assign rem_src[1] = num_p_ff[1];
         assign quo_src[0] = '0;
         assign quo_src[1] = '0;
         assign dist_src   = dist_p_ff;
         assign side_src   = side_p_ff;
         assign valid_src  = valid_p_ff;
      end else begin : g_next
         assign rem_src[0] = rem_ff[k-1][0];
         assign rem_src[1] = rem_ff[k-1][1];
         assign quo_src[0] = quo_ff[k-1][0];
         assign quo_src[1] = quo_ff[k-1][1];
         assign dist_src   = dist_ff[k-1];
         assign side_src   = side_ff[k-1];
         assign valid_src  = valid_ff[k-1];
      end

      assign trial = NW'(dist_src) << (BIT + 1);

      always_comb begin
         for (int ln = 0; ln < 2; ln++) begin
            if (rem_src[ln] >= trial) begin
               rem_in[ln] = rem_src[ln] - trial;
               quo_in[ln] = quo_src[ln] | (QW'(1) << BIT);
            end else begin
               rem_in[ln] = rem_src[ln];
               quo_in[ln] = quo_src[ln];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_src;
         end
         if (en) begin
            rem_ff[k][0] <= rem_in[0];
            rem_ff[k][1] <= rem_in[1];
            quo_ff[k][0] <= quo_in[0];
            quo_ff[k][1] <= quo_in[1];
            dist_ff[k]   <= dist_src;
            side_ff[k]   <= side_src;
         end
      end
   end

   // coincident centres give a zero normal; magnitude clamps to one
   function automatic logic [QW-1:0] clamp_q(input logic [QW-1:0] q, input logic zero);
      if (zero) begin
         return '0;
      end
      if (q > QW'(ccc_pkg::NORM_ONE)) begin
         return QW'(ccc_pkg::NORM_ONE);
      end
      return q;
   endfunction

   logic dist_zero;
   assign dist_zero  = (dist_ff[QW-1] == '0);
   assign out_valid  = valid_ff[QW-1];
   assign out_nmag_x = clamp_q(quo_ff[QW-1][0], dist_zero);
   assign out_nmag_y = clamp_q(quo_ff[QW-1][1], dist_zero);
   assign out_dist   = dist_ff[QW-1];
   assign out_side   = side_ff[QW-1];

endmodule

FILE: dv/tb_circle_circle_contact.sv
// testbench for the circle pair contact pipeline: directed table and random pairs
`timescale 1ns / 100ps

module tb_circle_circle_contact;

   localparam int unsigned CW       = ccc_pkg::COORD_WIDTH_DEF;
   localparam int unsigned RW       = ccc_pkg::RADIUS_WIDTH;
   localparam int unsigned NW       = ccc_pkg::NORM_WIDTH;
   localparam int unsigned DPW      = ccc_pkg::DEPTH_WIDTH;
   localparam int          WD_LIMIT = 20000;
   localparam int          N_RANDOM = 1600;

   typedef struct {
      logic signed [CW-1:0]           ax;
      logic signed [CW-1:0]           ay;
      logic [RW-1:0]                  ra;
      logic signed [CW-1:0]           bx;
      logic signed [CW-1:0]           by;
      logic [RW-1:0]                  rb;
   } pair_type;

   typedef struct {
      logic                           hit;
      logic signed [NW-1:0]           nx;
      logic signed [NW-1:0]           ny;
      logic signed [CW-1:0]           sx;
      logic signed [CW-1:0]           sy;
      logic signed [CW-1:0]           ex;
      logic signed [CW-1:0]           ey;
      logic [DPW-1:0]                 depth;
   } contact_type;

   typedef struct {
      pair_type    p;
      bit          typed;
      contact_type c;
   } row_type;

   typedef enum int {
      IDLE_SENDER_LIGHT,
      IDLE_SENDER_HEAVY,
      IDLE_NONE
   } idle_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ccc_req_if #(.COORD_WIDTH(CW)) req ();
   ccc_rsp_if #(.COORD_WIDTH(CW)) rsp ();

   circle_circle_contact #(.COORD_WIDTH(CW)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   always #4 clock = ~clock;

   contact_type   pending_contacts[$];
   bit            failed   = 1'b0;
   int            idle_cnt = 0;
   idle_mode_type idle_mode = IDLE_SENDER_LIGHT;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint clamp_coord(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic longint unit_comp(longint d, longint unsigned root);
      longint unsigned mag;
      longint unsigned q;
      if (root == 0) return 0;
      mag = (d < 0) ? -d : d;
      q = ((mag << ccc_pkg::DIV_SHIFT) + root) / (root << 1);
      if (q > ccc_pkg::NORM_ONE) q = ccc_pkg::NORM_ONE;
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint radius_offset(longint n, longint unsigned r);
      longint unsigned q;
      q = (((n < 0) ? -n : n) * r + ccc_pkg::PROD_ROUND) >> ccc_pkg::NORM_FRAC;
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic contact_type contact_of(pair_type p);
      contact_type     c;
      longint          dx;
      longint          dy;
      longint unsigned rsum;
      longint unsigned adx;
      longint unsigned ady;
      longint unsigned d2;
      longint unsigned root;
      longint          nx;
      longint          ny;
      c = '{default: '0};
      rsum = longint'(p.ra) + longint'(p.rb);
      dx = longint'(p.bx) - longint'(p.ax);
      dy = longint'(p.by) - longint'(p.ay);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      if (adx > rsum || ady > rsum) return c;
      d2 = adx * adx + ady * ady;
      if (d2 > rsum * rsum) return c;
      root = int_sqrt(d2 << 16);
      nx = unit_comp(dx, root);
      ny = unit_comp(dy, root);
      c.hit = 1'b1;
      c.nx = NW'(nx);
      c.ny = NW'(ny);
      c.sx = CW'(clamp_coord(longint'(p.bx) - radius_offset(nx, p.rb)));
      c.sy = CW'(clamp_coord(longint'(p.by) - radius_offset(ny, p.rb)));
      c.ex = CW'(clamp_coord(longint'(p.ax) + radius_offset(nx, p.ra)));
      c.ey = CW'(clamp_coord(longint'(p.ay) + radius_offset(ny, p.ra)));
      if (d2 == 0) c.depth = DPW'(rsum);
      else c.depth = DPW'((((rsum << 8) - root) + ccc_pkg::DEPTH_ROUND) >> 8);
      return c;
   endfunction

   task automatic check_field(string name, longint expd, longint act);
      if (expd != act) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, expd, act);
         failed = 1'b1;
      end
   endtask

   // receiver: ready at falling edge, item taken at rising edge
   always @(negedge clock) begin
      case (idle_mode)
         IDLE_SENDER_LIGHT: rsp.ready <= ($urandom_range(0, 99) >= 74);
         IDLE_SENDER_HEAVY: rsp.ready <= ($urandom_range(0, 99) >= 37);
         default:           rsp.ready <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      contact_type e;
      if (!reset && ((req.valid && req.ready) || (rsp.valid && rsp.ready)))
         idle_cnt <= 0;
      else
         idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WD_LIMIT) begin
         $display("[circle_circle_contact] ERROR");
         $finish;
      end
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_contacts.size() == 0) begin
            $display("%0t unexpected item collides %0b", $time, rsp.collides);
            failed = 1'b1;
         end else begin
            e = pending_contacts.pop_front();
            check_field("collides", e.hit, rsp.collides);
            check_field("normal_x", e.nx, rsp.normal_x);
            check_field("normal_y", e.ny, rsp.normal_y);
            check_field("start_x", e.sx, rsp.start_x);
            check_field("start_y", e.sy, rsp.start_y);
            check_field("end_x", e.ex, rsp.end_x);
            check_field("end_y", e.ey, rsp.end_y);
            check_field("depth", e.depth, rsp.depth);
         end
      end
   end

   task automatic send_pair(pair_type p, bit typed, contact_type c);
      contact_type model;
      int          gap;
      gap = (idle_mode == IDLE_SENDER_LIGHT) ? 37 : (idle_mode == IDLE_SENDER_HEAVY) ? 74 : 0;
      while ($urandom_range(0, 99) < gap) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid      <= 1'b1;
      req.center_a_x <= p.ax;
      req.center_a_y <= p.ay;
      req.radius_a   <= p.ra;
      req.center_b_x <= p.bx;
      req.center_b_y <= p.by;
      req.radius_b   <= p.rb;
      do @(posedge clock); while (!req.ready);
      model = contact_of(p);
      pending_contacts.insert(pending_contacts.size(), typed ? c : model);
      @(negedge clock);
   endtask

   function automatic logic signed [CW-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0:       return {1'b0, {(CW - 1){1'b1}}};
         1:       return {1'b1, {(CW - 1){1'b0}}};
         2:       return CW'(longint'($urandom_range(0, 4095)) - 2048);
         default: return CW'($urandom);
      endcase
   endfunction

   function automatic pair_type rand_pair();
      pair_type p;
      longint   rsum;
      longint   dx;
      longint   dy;
      longint   hi;
      hi = (longint'(1) << (CW - 1)) - 1;
      p.ax = rand_coord();
      p.ay = rand_coord();
      p.ra = RW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 2047));
      p.rb = RW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 2047));
      if ($urandom_range(0, 4) == 0) begin
         p.bx = CW'($urandom);
         p.by = CW'($urandom);
         p.ra = RW'($urandom);
         p.rb = RW'($urandom);
         return p;
      end
      rsum = longint'(p.ra) + longint'(p.rb);
      dx = longint'($urandom_range(0, 32'(2 * rsum + 2))) - rsum - 1;
      dy = longint'($urandom_range(0, 32'(2 * rsum + 2))) - rsum - 1;
      if ($urandom_range(0, 7) == 0) dy = 0;
      if (longint'(p.ax) + dx > hi || longint'(p.ax) + dx < -hi - 1) dx = -dx;
      if (longint'(p.ay) + dy > hi || longint'(p.ay) + dy < -hi - 1) dy = -dy;
      p.bx = CW'(longint'(p.ax) + dx);
      p.by = CW'(longint'(p.ay) + dy);
      return p;
   endfunction

   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW - 1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW - 1){1'b0}}};

   contact_type miss = '{default: '0};

   row_type directed[] = '{
      '{'{0, 0, 0, 0, 0, 0}, 1, '{1, 0, 0, 0, 0, 0, 0, 0}},
      '{'{100, -50, 300, 100, -50, 200}, 1, '{1, 0, 0, 100, -50, 100, -50, 500}},
      '{'{CMAX, CMIN, 16'hFFFF, CMAX, CMIN, 16'hFFFF},
        1, '{1, 0, 0, CMAX, CMIN, CMAX, CMIN, 17'h1FFFE}},
      '{'{0, 0, 256, 512, 0, 256}, 1, '{1, 16384, 0, 256, 0, 256, 0, 0}},
      '{'{0, 0, 256, 0, -512, 256}, 1, '{1, 0, -16384, 0, -256, 0, -256, 0}},
      '{'{0, 0, 256, 513, 0, 256}, 1, '{0, 0, 0, 0, 0, 0, 0, 0}},
      '{'{CMIN, CMIN, 0, CMAX, CMAX, 0}, 1, '{0, 0, 0, 0, 0, 0, 0, 0}},
      '{'{CMAX, 0, 16'hFFFF, CMAX - 100, 0, 16'hFFFF}, 0, '{default: '0}},
      '{'{CMIN, CMIN, 16'hFFFF, CMIN + 300, CMIN + 400, 16'hFFFF}, 0, '{default: '0}},
      '{'{CMIN + 10, CMAX - 10, 16'h8000, CMIN + 20, CMAX - 20, 16'h0001}, 0, '{default: '0}},
      '{'{0, 0, 16'hFFFF, 131070, 0, 16'hFFFF}, 0, '{default: '0}},
      '{'{0, 0, 16'hFFFF, -92681, -92681, 16'hFFFF}, 0, '{default: '0}},
      '{'{-300, 700, 1000, 500, -100, 900}, 0, '{default: '0}},
      '{'{5, 5, 3, 6, 7, 1}, 0, '{default: '0}},
      '{'{0, 0, 1, 1, 0, 0}, 0, '{default: '0}},
      '{'{-1, -1, 12345, 4000, -7000, 23456}, 0, '{default: '0}},
      '{'{CMAX, CMAX, 16'h00FF, CMAX - 300, CMAX - 300, 16'h0100}, 0, '{default: '0}}
   };

   initial begin
      req.valid      = 1'b0;
      req.center_a_x = '0;
      req.center_a_y = '0;
      req.radius_a   = '0;
      req.center_b_x = '0;
      req.center_b_y = '0;
      req.radius_b   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) send_pair(directed[i].p, directed[i].typed, directed[i].c);

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 3) idle_mode = IDLE_SENDER_HEAVY;
         if (i == 2 * N_RANDOM / 3) idle_mode = IDLE_NONE;
         send_pair(rand_pair(), 1'b0, miss);
      end
      req.valid <= 1'b0;

      while (pending_contacts.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (!failed) begin
         $display("[circle_circle_contact] OK");
      end else begin
         $display("[circle_circle_contact] ERROR");
      end
      $finish;
   end

endmodule
